[hdl/vlff_pkg.sv]
// shared constants and types for the voxel light flood fill unit
package vlff_pkg;
   localparam int GRID_BITS   = 4;
   localparam int LIGHT_MAX   = 15;
   localparam int QUEUE_DEPTH = 4096;
   localparam int CELL_W   = 3 * GRID_BITS;
   localparam int CELLS    = 1 << CELL_W;
   localparam int LVL_W    = 4;
   localparam int QA_W     = $clog2(QUEUE_DEPTH);
   localparam int QC_W     = QA_W + 1;
   localparam int QE_W     = CELL_W + LVL_W;

   localparam logic [2:0] CMD_SOLID  = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_RESEED = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_SOLVE  = 3'd4;
   localparam logic [2:0] CMD_READ   = 3'd5;
   localparam logic [2:0] CMD_NOP    = 3'd7;

   typedef struct packed {
      logic [2:0]        command;
      logic [CELL_W-1:0] voxel;
      logic [LVL_W-1:0]  level;
      logic              outside;
   } cmd_type;
endpackage

[hdl/vlff_if.sv]
// valid/ready channel interfaces for requests and responses
interface vlff_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [3:0] pos_x;
   logic [3:0] pos_y;
   logic [3:0] pos_z;
   logic [3:0] level;
   modport source (output valid, command, pos_x, pos_y, pos_z, level, input ready);
   modport sink   (input valid, command, pos_x, pos_y, pos_z, level, output ready);
endinterface

interface vlff_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] light_level;
   logic       queue_overflow;
   modport source (output valid, light_level, queue_overflow, input ready);
   modport sink   (input valid, light_level, queue_overflow, output ready);
endinterface

[hdl/vlff_ram.sv]
// generic single-port ram with registered read
module vlff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[hdl/vlff_front.sv]
// front end: accepts requests, drops out-of-grid cells, queues commands
module vlff_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              block_in,
   vlff_req_if.sink          req,
   output logic              cq_valid,
   output vlff_pkg::cmd_type cq_data,
   input  logic              cq_pop
);
   localparam int GW = vlff_pkg::GRID_BITS;
   vlff_pkg::cmd_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push;
   vlff_pkg::cmd_type item;
   logic [3:0] maxc;

   // coordinates above the grid read back as 0 and do nothing
   always_comb begin
      maxc = 4'((1 << GW) - 1);
      item.voxel = {req.pos_x[GW-1:0], req.pos_y[GW-1:0], req.pos_z[GW-1:0]};
      item.command = req.command;
      item.level = req.level;
      item.outside = 1'b0;
      if (req.command != vlff_pkg::CMD_SOLVE &&
          (req.pos_x > maxc || req.pos_y > maxc || req.pos_z > maxc)) begin
         item.command = vlff_pkg::CMD_NOP;
         item.voxel = '0;
         item.outside = 1'b1;
      end
   end

   assign req.ready = (cnt_ff != 2'd2) && !block_in;
   assign push = req.valid && req.ready;
   assign cq_valid = cnt_ff != 2'd0;
   assign cq_data = buf_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(cq_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (cq_pop) rd_ff <= !rd_ff;
      end
      if (push) buf_ff[wr_ff] <= item;
   end
endmodule

[hdl/vlff_back.sv]
// back end: grid memories, bfs queues and command execution sequencer
module vlff_back (
   input  logic              clock,
   input  logic              reset,
   output logic              busy_out,
   input  logic              cq_valid,
   input  vlff_pkg::cmd_type cq_data,
   output logic              cq_pop,
   vlff_rsp_if.source        rsp
);
   localparam int CW = vlff_pkg::CELL_W;
   localparam int GW = vlff_pkg::GRID_BITS;
   localparam int LW = vlff_pkg::LVL_W;
   localparam int AW = vlff_pkg::QA_W;
   localparam int NW = vlff_pkg::QC_W;
   localparam int EW = vlff_pkg::QE_W;
   localparam logic [GW-1:0] GMAX = {GW{1'b1}};
   localparam logic [LW-1:0] LMAX = LW'(vlff_pkg::LIGHT_MAX);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_RSP   = 4'd4;
   localparam logic [3:0] S_QPOP  = 4'd5;
   localparam logic [3:0] S_QWAIT = 4'd6;
   localparam logic [3:0] S_NADDR = 4'd7;
   localparam logic [3:0] S_NWAIT = 4'd8;
   localparam logic [3:0] S_NEVAL = 4'd9;
   localparam logic [3:0] S_RRD   = 4'd10;

   logic [3:0]  st_ff, st_in;
   logic [CW-1:0] clr_ff;
   vlff_pkg::cmd_type c_ff;
   logic [CW-1:0] cur_cell_ff, nb_ff;
   logic [LW-1:0] cur_lvl_ff;
   logic          phase_ff;      // 0 removal drain, 1 spread drain
   logic [2:0]    k_ff;
   logic [NW-1:0] rcnt_ff, scnt_ff;
   logic [AW-1:0] rh_ff, rt_ff, sh_ff, st2_ff;
   logic          ovf_ff;
   logic [LW-1:0] out_lvl_ff;
   logic          out_v_ff;

   // grid memory ports
   logic          g_we;
   logic [CW-1:0] g_addr;
   logic [LW:0]   g_wd, g_rd;
   // queue memory ports
   logic          r_we, s_we;
   logic [AW-1:0] r_addr, s_addr;
   logic [EW-1:0] r_wd, s_wd, r_rd, s_rd;

   // combinational decisions
   logic          push_r, push_s;
   logic [EW-1:0] push_e;
   logic [LW-1:0] g_lvl;
   logic          g_sol;
   logic [LW-1:0] seed_l;
   logic [GW-1:0] cx, cy, cz, nx, ny, nz;
   logic          nok;
   logic [LW:0]   nl1;

   vlff_ram #(.WIDTH(LW + 1), .DEPTH(vlff_pkg::CELLS)) u_grid (
      .clock(clock), .wr_en(g_we), .addr(g_addr), .wr_data(g_wd), .rd_data(g_rd));
   vlff_ram #(.WIDTH(EW), .DEPTH(vlff_pkg::QUEUE_DEPTH)) u_rq (
      .clock(clock), .wr_en(r_we), .addr(r_addr), .wr_data(r_wd), .rd_data(r_rd));
   vlff_ram #(.WIDTH(EW), .DEPTH(vlff_pkg::QUEUE_DEPTH)) u_sq (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));

   assign g_lvl = g_rd[LW-1:0];
   assign g_sol = g_rd[LW];
   assign busy_out = st_ff == S_CLEAR;
   assign rsp.valid = out_v_ff;
   assign rsp.light_level = out_lvl_ff;
   assign rsp.queue_overflow = ovf_ff;

   // neighbor k of the current cell
   always_comb begin
      cx = cur_cell_ff[CW-1 -: GW];
      cy = cur_cell_ff[2*GW-1 -: GW];
      cz = cur_cell_ff[GW-1:0];
      nx = cx; ny = cy; nz = cz; nok = 1'b1;
      case (k_ff)
         3'd0: begin nok = cz != GMAX; nz = cz + 1'b1; end
         3'd1: begin nok = cz != '0;   nz = cz - 1'b1; end
         3'd2: begin nok = cy != GMAX; ny = cy + 1'b1; end
         3'd3: begin nok = cy != '0;   ny = cy - 1'b1; end
         3'd4: begin nok = cx != GMAX; nx = cx + 1'b1; end
         default: begin nok = cx != '0; nx = cx - 1'b1; end
      endcase
   end

   assign seed_l = (c_ff.command == vlff_pkg::CMD_ADD) ?
                   ((c_ff.level > LMAX) ? LMAX : c_ff.level) : g_lvl;
   assign nl1 = {1'b0, g_lvl} + 1'b1;

   always_comb begin
      st_in = st_ff;
      g_we = 1'b0; g_addr = c_ff.voxel; g_wd = g_rd;
      r_we = 1'b0; s_we = 1'b0;
      r_addr = rh_ff; s_addr = sh_ff;
      push_r = 1'b0; push_s = 1'b0;
      push_e = '0;
      cq_pop = 1'b0;
      case (st_ff)
         S_CLEAR: begin
            g_we = 1'b1; g_addr = clr_ff; g_wd = '0;
            if (clr_ff == {CW{1'b1}}) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (cq_valid && !out_v_ff) begin
               cq_pop = 1'b1;
               st_in = (cq_data.command == vlff_pkg::CMD_SOLVE) ? S_QPOP : S_RD;
            end
         end
         S_RD: st_in = S_EXEC;
         S_EXEC: begin
            st_in = S_RRD;
            case (c_ff.command)
               vlff_pkg::CMD_SOLID: begin
                  g_we = 1'b1; g_wd = {c_ff.level != '0, g_lvl};
               end
               vlff_pkg::CMD_ADD, vlff_pkg::CMD_RESEED: begin
                  if (seed_l > LW'(1)) begin
                     g_we = 1'b1; g_wd = {g_sol, seed_l};
                     push_s = 1'b1; push_e = {c_ff.voxel, seed_l};
                  end
               end
               vlff_pkg::CMD_REMOVE: begin
                  if (g_lvl != '0) begin
                     g_we = 1'b1; g_wd = {g_sol, {LW{1'b0}}};
                     push_r = 1'b1; push_e = {c_ff.voxel, g_lvl};
                  end
               end
               default: ;
            endcase
         end
         S_RRD: st_in = S_RSP;
         S_RSP: st_in = S_IDLE;
         S_QPOP: begin
            if (rcnt_ff != '0) begin
               st_in = S_QWAIT;
            end else if (scnt_ff != '0) begin
               st_in = S_QWAIT;
            end else begin
               st_in = S_RSP;
            end
         end
         S_QWAIT: st_in = S_NADDR;
         S_NADDR: begin
            g_addr = {nx, ny, nz};
            if (!phase_ff && cur_lvl_ff == '0) st_in = S_NADDR;
            if (phase_ff && cur_lvl_ff <= LW'(1)) st_in = S_QPOP;
            else if (!nok) st_in = (k_ff == 3'd5) ? S_QPOP : S_NADDR;
            else st_in = S_NWAIT;
         end
         S_NWAIT: begin g_addr = nb_ff; st_in = S_NEVAL; end
         S_NEVAL: begin
            g_addr = nb_ff;
            st_in = (k_ff == 3'd5) ? S_QPOP : S_NADDR;
            if (!phase_ff) begin
               if (g_lvl != '0 && nl1 == {1'b0, cur_lvl_ff}) begin
                  push_r = 1'b1; push_e = {nb_ff, g_lvl};
                  g_we = 1'b1; g_wd = {g_sol, {LW{1'b0}}};
               end else if (g_lvl >= cur_lvl_ff) begin
                  push_s = 1'b1; push_e = {nb_ff, g_lvl};
               end
            end else if (!g_sol && nl1 < {1'b0, cur_lvl_ff}) begin
               g_we = 1'b1; g_wd = {g_sol, cur_lvl_ff - 1'b1};
               push_s = 1'b1; push_e = {nb_ff, cur_lvl_ff - 1'b1};
            end
         end
         default: st_in = S_IDLE;
      endcase
      r_wd = push_e; s_wd = push_e;
      if (push_r && rcnt_ff != NW'(vlff_pkg::QUEUE_DEPTH)) begin
         r_we = 1'b1; r_addr = rt_ff;
      end
      if (push_s && scnt_ff != NW'(vlff_pkg::QUEUE_DEPTH)) begin
         s_we = 1'b1; s_addr = st2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         clr_ff <= '0;
         rcnt_ff <= '0; scnt_ff <= '0;
         rh_ff <= '0; rt_ff <= '0; sh_ff <= '0; st2_ff <= '0;
         ovf_ff <= 1'b0;
         out_v_ff <= 1'b0;
         phase_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rsp.valid && rsp.ready) out_v_ff <= 1'b0;
         if (st_ff == S_RSP) begin
            out_v_ff <= 1'b1;
            out_lvl_ff <= c_ff.outside ? '0 : g_lvl;
         end
         if (st_ff == S_IDLE && cq_pop) c_ff <= cq_data;
         // queue bookkeeping
         if (push_r) begin
            if (r_we) begin rt_ff <= rt_ff + 1'b1; end else ovf_ff <= 1'b1;
         end
         if (push_s) begin
            if (s_we) begin st2_ff <= st2_ff + 1'b1; end else ovf_ff <= 1'b1;
         end
         if (st_ff == S_QPOP) begin
            k_ff <= '0;
            if (rcnt_ff != '0) begin
               phase_ff <= 1'b0; rh_ff <= rh_ff + 1'b1;
            end else if (scnt_ff != '0) begin
               phase_ff <= 1'b1; sh_ff <= sh_ff + 1'b1;
            end
         end
         rcnt_ff <= rcnt_ff + NW'(r_we) -
                    NW'(st_ff == S_QPOP && rcnt_ff != '0);
         scnt_ff <= scnt_ff + NW'(s_we) -
                    NW'(st_ff == S_QPOP && rcnt_ff == '0 && scnt_ff != '0);
         if (st_ff == S_NADDR) begin
            nb_ff <= {nx, ny, nz};
            if (!nok && !(phase_ff && cur_lvl_ff <= LW'(1))) k_ff <= k_ff + 1'b1;
         end
         if (st_ff == S_NEVAL) k_ff <= k_ff + 1'b1;
      end
      if (st_ff == S_QWAIT) begin
         {cur_cell_ff, cur_lvl_ff} <= phase_ff ? s_rd : r_rd;
      end
   end
endmodule

[hdl/voxel_light_flood_fill_unit.sv]
// Top level: voxel light flood fill unit.
// A cell command or read passes the read, execute, reread and respond states;
// a solve drains the removal queue, then the spread queue, reading and
// evaluating each in-grid neighbor of each entry popped (a spent spread entry
// visits none). One command executes at a time; the next waits for the
// response transfer. After reset the grid is cleared one cell a cycle (all 4096
// cells) before any request is taken; queues and overflow flag reset empty.
module voxel_light_flood_fill_unit (
   input  logic       clock,
   input  logic       reset,
   vlff_req_if.sink   req,
   vlff_rsp_if.source rsp
);
   logic              cq_valid, cq_pop, busy;
   vlff_pkg::cmd_type cq_data;

   vlff_front u_front (
      .clock(clock), .reset(reset), .block_in(busy), .req(req),
      .cq_valid(cq_valid), .cq_data(cq_data), .cq_pop(cq_pop));

   vlff_back u_back (
      .clock(clock), .reset(reset), .busy_out(busy),
      .cq_valid(cq_valid), .cq_data(cq_data), .cq_pop(cq_pop), .rsp(rsp));
endmodule

[dv/tb_top.sv]
// testbench for the voxel light flood fill unit: directed and random commands checked against a light model
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      logic [2:0] command;
      logic [3:0] pos_x;
      logic [3:0] pos_y;
      logic [3:0] pos_z;
      logic [3:0] level;
   } light_cmd_type;

   typedef struct {
      logic [3:0] light_level;
      logic       queue_overflow;
   } light_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vlff_req_if req ();
   vlff_rsp_if rsp ();

   voxel_light_flood_fill_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [3:0]  light_map [vlff_pkg::CELLS];
   logic        solid_map [vlff_pkg::CELLS];
   logic [11:0] rmv_cell [$];
   logic [3:0]  rmv_lvl [$];
   logic [11:0] spr_cell [$];
   logic [3:0]  spr_lvl [$];
   logic        overflow_seen;

   light_cmd_type pending_cmds [$];
   light_rsp_type expected_levels [$];
   int            error_count;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void push_removal(input logic [11:0] c, input logic [3:0] l);
      if (rmv_cell.size() >= vlff_pkg::QUEUE_DEPTH) overflow_seen = 1'b1;
      else begin
         rmv_cell.push_back(c);
         rmv_lvl.push_back(l);
      end
   endfunction

   function automatic void push_spread(input logic [11:0] c, input logic [3:0] l);
      if (spr_cell.size() >= vlff_pkg::QUEUE_DEPTH) overflow_seen = 1'b1;
      else begin
         spr_cell.push_back(c);
         spr_lvl.push_back(l);
      end
   endfunction

   function automatic bit step_neighbor(input logic [11:0] c, input int k,
                                        output logic [11:0] n);
      logic [3:0] x, y, z;
      x = c[11:8];
      y = c[7:4];
      z = c[3:0];
      case (k)
         0: begin if (z == 4'hf) return 0; z++; end
         1: begin if (z == 4'h0) return 0; z--; end
         2: begin if (y == 4'hf) return 0; y++; end
         3: begin if (y == 4'h0) return 0; y--; end
         4: begin if (x == 4'hf) return 0; x++; end
         default: begin if (x == 4'h0) return 0; x--; end
      endcase
      n = {x, y, z};
      return 1;
   endfunction

   function automatic void seed_light(input logic [11:0] c, input logic [3:0] l);
      if (l > 1) begin
         push_spread(c, l);
         light_map[c] = l;
      end
   endfunction

   function automatic void propagate_light();
      logic [11:0] c, n;
      logic [3:0]  l, nl;
      while (rmv_cell.size() != 0) begin
         c = rmv_cell.pop_front();
         l = rmv_lvl.pop_front();
         for (int k = 0; k < 6; k++) begin
            if (!step_neighbor(c, k, n)) continue;
            nl = light_map[n];
            if (nl != 0 && 5'(nl) + 5'd1 == 5'(l)) begin
               push_removal(n, nl);
               light_map[n] = 4'd0;
            end else if (nl >= l) begin
               push_spread(n, nl);
            end
         end
      end
      while (spr_cell.size() != 0) begin
         c = spr_cell.pop_front();
         l = spr_lvl.pop_front();
         if (l <= 1) continue;
         for (int k = 0; k < 6; k++) begin
            if (!step_neighbor(c, k, n)) continue;
            if (!solid_map[n] && 5'(light_map[n]) + 5'd1 < 5'(l)) begin
               light_map[n] = l - 4'd1;
               push_spread(n, l - 4'd1);
            end
         end
      end
   endfunction

   function automatic light_rsp_type predict_light(input light_cmd_type t);
      light_rsp_type r;
      logic [11:0] c;
      c = {t.pos_x, t.pos_y, t.pos_z};
      case (t.command)
         vlff_pkg::CMD_SOLVE:  propagate_light();
         vlff_pkg::CMD_SOLID:  solid_map[c] = (t.level != 0);
         vlff_pkg::CMD_ADD:    seed_light(c, t.level);
         vlff_pkg::CMD_RESEED: seed_light(c, light_map[c]);
         vlff_pkg::CMD_REMOVE: begin
            if (light_map[c] != 0) begin
               push_removal(c, light_map[c]);
               light_map[c] = 4'd0;
            end
         end
         default: ;
      endcase
      r.light_level = light_map[c];
      r.queue_overflow = overflow_seen;
      return r;
   endfunction

   function automatic light_cmd_type make_cmd(input logic [2:0] op, input logic [3:0] x,
                                              input logic [3:0] y, input logic [3:0] z,
                                              input logic [3:0] l);
      light_cmd_type t;
      t.command = op;
      t.pos_x = x;
      t.pos_y = y;
      t.pos_z = z;
      t.level = l;
      return t;
   endfunction

   function automatic light_cmd_type random_cmd();
      int pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 12) op = vlff_pkg::CMD_SOLID;
      else if (pick < 40) op = vlff_pkg::CMD_ADD;
      else if (pick < 48) op = vlff_pkg::CMD_RESEED;
      else if (pick < 60) op = vlff_pkg::CMD_REMOVE;
      else if (pick < 75) op = vlff_pkg::CMD_SOLVE;
      else if (pick < 96) op = vlff_pkg::CMD_READ;
      else op = 3'($urandom_range(6, 7));
      // cluster most activity in a small region so light interacts
      if ($urandom_range(0, 3) != 0)
         return make_cmd(op, 4'($urandom_range(4, 9)), 4'($urandom_range(4, 9)),
                         4'($urandom_range(4, 9)), 4'($urandom));
      return make_cmd(op, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
   endfunction

   // driver
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req.valid || req.ready) begin
         if (send_gap > 0) begin
            req.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_cmds.size() != 0) begin
            light_cmd_type t;
            t = pending_cmds.pop_front();
            req.valid <= 1'b1;
            req.command <= t.command;
            req.pos_x <= t.pos_x;
            req.pos_y <= t.pos_y;
            req.pos_z <= t.pos_z;
            req.level <= t.level;
            expected_levels.push_back(predict_light(t));
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   int hold_off;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_off <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               light_rsp_type w;
               w = expected_levels.pop_front();
               if (rsp.light_level !== w.light_level)
                  report_mismatch("light_level", rsp.light_level, w.light_level);
               if (rsp.queue_overflow !== w.queue_overflow)
                  report_mismatch("queue_overflow", rsp.queue_overflow, w.queue_overflow);
            end
            hold_off <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            rsp.ready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.command = vlff_pkg::CMD_READ;
      req.pos_x = 4'd0;
      req.pos_y = 4'd0;
      req.pos_z = 4'd0;
      req.level = 4'd0;
      rsp.ready = 1'b0;
      error_count = 0;
      overflow_seen = 1'b0;
      for (int i = 0; i < vlff_pkg::CELLS; i++) begin
         light_map[i] = 4'd0;
         solid_map[i] = 1'b0;
      end
      // directed: corners, extremes, weak and saturated sources, solid cells
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_READ, 4'd0, 4'd0, 4'd0, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_ADD, 4'd15, 4'd15, 4'd15, 4'd15));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_ADD, 4'd0, 4'd0, 4'd0, 4'd1));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_ADD, 4'd0, 4'd0, 4'd0, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLID, 4'd14, 4'd15, 4'd15, 4'd15));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLVE, 4'd0, 4'd0, 4'd0, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_READ, 4'd14, 4'd15, 4'd15, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_READ, 4'd15, 4'd15, 4'd10, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_REMOVE, 4'd15, 4'd15, 4'd15, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_REMOVE, 4'd0, 4'd0, 4'd0, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLVE, 4'd5, 4'd5, 4'd5, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_READ, 4'd15, 4'd15, 4'd12, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_ADD, 4'd7, 4'd7, 4'd7, 4'd2));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_RESEED, 4'd7, 4'd7, 4'd7, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_RESEED, 4'd1, 4'd2, 4'd3, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLID, 4'd7, 4'd7, 4'd7, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLVE, 4'd0, 4'd0, 4'd0, 4'd0));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_READ, 4'd7, 4'd7, 4'd8, 4'd0));
      pending_cmds.push_back(make_cmd(3'd6, 4'd7, 4'd7, 4'd7, 4'd9));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_NOP, 4'd15, 4'd0, 4'd15, 4'd15));
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_NOP, 4'd0, 4'd0, 4'd0, 4'd0));
      for (int i = 0; i < 880; i++) pending_cmds.push_back(random_cmd());
      pending_cmds.push_back(make_cmd(vlff_pkg::CMD_SOLVE, 4'd0, 4'd0, 4'd0, 4'd0));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && expected_levels.size() == 0 && !req.valid);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   // a solve can pop thousands of queue entries, each visiting up to six neighbors
   initial begin
      #3s;
      $display("Test completed with failures");
      $finish;
   end

endmodule
